/* rtl/core/lc3x_pkg.sv */
`default_nettype none

package lc3x_pkg;

  localparam int unsigned XLen    = 16;
  localparam int unsigned RegAw   = 3;
  localparam int unsigned RegNum  = 8;
  localparam int unsigned FlagW   = 3;

  localparam logic [RegAw-1:0] RegLink = 3'd7;

  localparam logic [FlagW-1:0] FlagPos = 3'b001;
  localparam logic [FlagW-1:0] FlagZro = 3'b010;
  localparam logic [FlagW-1:0] FlagNeg = 3'b100;

  typedef enum logic [3:0] {
    OP_BR   = 4'd0,
    OP_ADD  = 4'd1,
    OP_LD   = 4'd2,
    OP_ST   = 4'd3,
    OP_JSR  = 4'd4,
    OP_AND  = 4'd5,
    OP_LDR  = 4'd6,
    OP_STR  = 4'd7,
    OP_RTI  = 4'd8,
    OP_NOT  = 4'd9,
    OP_LDI  = 4'd10,
    OP_STI  = 4'd11,
    OP_JMP  = 4'd12,
    OP_RES  = 4'd13,
    OP_LEA  = 4'd14,
    OP_TRAP = 4'd15
  } op_e;

  // Everything one instruction leaves behind: architectural state and the result beat.
  typedef struct packed {
    logic [XLen-1:0]  pc;
    logic [FlagW-1:0] flags;
    logic             halt;
    logic             wr;
    logic [RegAw-1:0] wreg;
    logic [XLen-1:0]  wval;
    logic             unimp;
  } exec_out_t;

endpackage

`default_nettype wire

/* rtl/core/lc3x_in_if.sv */
`default_nettype none

interface lc3x_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] instr;

  modport source (output valid, output instr, input ready);
  modport sink   (input valid, input instr, output ready);
endinterface

`default_nettype wire

/* rtl/core/lc3x_out_if.sv */
`default_nettype none

interface lc3x_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] fetch_address;
  logic        wrote;
  logic [2:0]  written_reg;
  logic [15:0] written_value;
  logic [2:0]  cond_flags;
  logic        halted;
  logic        unimplemented;

  modport source (
    output valid, output fetch_address, output wrote, output written_reg,
    output written_value, output cond_flags, output halted, output unimplemented,
    input ready
  );
  modport sink (
    input valid, input fetch_address, input wrote, input written_reg,
    input written_value, input cond_flags, input halted, input unimplemented,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/core/lc3x_cfg_if.sv */
`default_nettype none

interface lc3x_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] start_address;

  modport source (output valid, output start_address, input ready);
  modport sink   (input valid, input start_address, output ready);
endinterface

`default_nettype wire

/* rtl/core/lc3x_ram.sv */
`default_nettype none

module lc3x_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/core/lc3x_regfile.sv */
`default_nettype none

module lc3x_regfile
  import lc3x_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [RegAw-1:0] raddr_a_i,
  input  wire logic [RegAw-1:0] raddr_b_i,
  input  wire logic             we_i,
  input  wire logic [RegAw-1:0] waddr_i,
  input  wire logic [XLen-1:0]  wdata_i,
  output      logic [XLen-1:0]  rdata_a_o,
  output      logic [XLen-1:0]  rdata_b_o
);

  logic [RegNum-1:0] vld_q, vld_d;
  logic              vld_a_q, vld_b_q;
  logic [RegAw-1:0]  raddr_a_q, raddr_b_q;
  logic              byp_we_q;
  logic [RegAw-1:0]  byp_addr_q;
  logic [XLen-1:0]   byp_data_q;
  logic [XLen-1:0]   ram_a, ram_b;

  lc3x_ram #(.Width(XLen), .Depth(RegNum)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_i),
    .waddr_i (waddr_i),
    .wdata_i (wdata_i),
    .raddr_i (raddr_a_i),
    .rdata_o (ram_a)
  );

  lc3x_ram #(.Width(XLen), .Depth(RegNum)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_i),
    .waddr_i (waddr_i),
    .wdata_i (wdata_i),
    .raddr_i (raddr_b_i),
    .rdata_o (ram_b)
  );

  always_comb begin
    vld_d = vld_q;
    if (we_i) begin
      vld_d[waddr_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_a_q  <= 1'b0;
      vld_b_q  <= 1'b0;
      byp_we_q <= 1'b0;
    end else begin
      vld_q    <= vld_d;
      vld_a_q  <= vld_q[raddr_a_i];
      vld_b_q  <= vld_q[raddr_b_i];
      byp_we_q <= we_i;
    end
  end

  always_ff @(posedge clk_i) begin
    raddr_a_q  <= raddr_a_i;
    raddr_b_q  <= raddr_b_i;
    byp_addr_q <= waddr_i;
    byp_data_q <= wdata_i;
  end

  // The RAM reads before the write of the same edge; forward that write.
  always_comb begin
    if (byp_we_q && (byp_addr_q == raddr_a_q)) begin
      rdata_a_o = byp_data_q;
    end else if (vld_a_q) begin
      rdata_a_o = ram_a;
    end else begin
      rdata_a_o = '0;
    end
    if (byp_we_q && (byp_addr_q == raddr_b_q)) begin
      rdata_b_o = byp_data_q;
    end else if (vld_b_q) begin
      rdata_b_o = ram_b;
    end else begin
      rdata_b_o = '0;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lc3x_exec.sv */
`default_nettype none

module lc3x_exec
  import lc3x_pkg::*;
(
  input  wire logic [XLen-1:0]  instr_i,
  input  wire logic [XLen-1:0]  src_a_i,
  input  wire logic [XLen-1:0]  src_b_i,
  input  wire logic [XLen-1:0]  pc_i,
  input  wire logic [FlagW-1:0] flags_i,
  input  wire logic             halt_i,
  output      exec_out_t        res_o
);

  op_e              op;
  logic [XLen-1:0]  pc_inc;
  logic [XLen-1:0]  imm5;
  logic [XLen-1:0]  off9;
  logic [XLen-1:0]  off11;
  logic [XLen-1:0]  opnd_b;
  logic [XLen-1:0]  alu;
  logic [FlagW-1:0] alu_flags;

  assign op     = op_e'(instr_i[15:12]);
  assign pc_inc = pc_i + 16'd1;
  assign imm5   = {{11{instr_i[4]}}, instr_i[4:0]};
  assign off9   = {{7{instr_i[8]}}, instr_i[8:0]};
  assign off11  = {{5{instr_i[10]}}, instr_i[10:0]};
  assign opnd_b = instr_i[5] ? imm5 : src_b_i;

  always_comb begin
    case (op)
      OP_ADD:  alu = src_a_i + opnd_b;
      OP_AND:  alu = src_a_i & opnd_b;
      OP_NOT:  alu = ~src_a_i;
      default: alu = pc_inc;
    endcase
  end

  always_comb begin
    if (alu == '0) begin
      alu_flags = FlagZro;
    end else if (alu[XLen-1]) begin
      alu_flags = FlagNeg;
    end else begin
      alu_flags = FlagPos;
    end
  end

  always_comb begin
    res_o       = '0;
    res_o.pc    = pc_i;
    res_o.flags = flags_i;
    res_o.halt  = halt_i;
    if (!halt_i) begin
      res_o.pc = pc_inc;
      case (op)
        OP_ADD, OP_AND, OP_NOT: begin
          res_o.wr    = 1'b1;
          res_o.wreg  = instr_i[11:9];
          res_o.wval  = alu;
          res_o.flags = alu_flags;
        end
        OP_BR: begin
          if (|(instr_i[11:9] & flags_i)) begin
            res_o.pc = pc_inc + off9;
          end
        end
        OP_JMP: begin
          res_o.pc = src_a_i;
        end
        OP_JSR: begin
          res_o.wr   = 1'b1;
          res_o.wreg = RegLink;
          res_o.wval = pc_inc;
          if (instr_i[11]) begin
            res_o.pc = pc_inc + off11;
          end else if (instr_i[8:6] == RegLink) begin
            // link register is written first, so the base reads the new value
            res_o.pc = pc_inc;
          end else begin
            res_o.pc = src_a_i;
          end
        end
        OP_TRAP: begin
          res_o.halt = 1'b1;
        end
        OP_RTI, OP_RES: begin
        end
        default: begin
          res_o.unimp = 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lc3_subset_execute_unit_top.sv */
`default_nettype none

// Executes a subset of the LC-3 instruction set, one instruction word per input beat.
// Supported are ADD, AND, NOT, BR, JMP, JSR/JSRR and TRAP (which halts the unit);
// loads, stores and LEA only raise the unimplemented bit. Each beat returns exactly one
// result beat carrying the next fetch address, the register write and the N/Z/P flags.
// Throughput is one instruction per clock while the output is not stalled; an accepted
// instruction waits in the input register while the register file is read, then the
// execute logic loads the result register. The register file is a RAM
// with registered reads and a forwarding path from the write of the same edge, which is
// what lets dependent instructions follow back to back. After a TRAP every beat is
// answered with the current state and halted set. Writing start_address loads the PC;
// do so only while no instruction is in flight.
module lc3_subset_execute_unit_top
  import lc3x_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  lc3x_cfg_if.sink    cfg_i,
  lc3x_in_if.sink     in_i,
  lc3x_out_if.source  out_o
);

  logic             in_vld_q, in_vld_d;
  logic [XLen-1:0]  instr_q;
  logic             in_rdy;
  logic             in_acc;
  logic             ex_fire;
  logic [XLen-1:0]  pc_q, pc_d;
  logic [FlagW-1:0] flags_q, flags_d;
  logic             halt_q, halt_d;
  logic             out_vld_q, out_vld_d;
  exec_out_t        res_q;
  exec_out_t        ex_res;
  logic [XLen-1:0]  rd_instr;
  logic [XLen-1:0]  src_a;
  logic [XLen-1:0]  src_b;

  assign ex_fire = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_rdy  = !in_vld_q || ex_fire;
  assign in_acc  = in_i.valid && in_rdy;

  assign in_i.ready  = in_rdy;
  assign cfg_i.ready = 1'b1;

  // Read the operands of whichever beat sits in the input register next cycle.
  assign rd_instr = in_rdy ? in_i.instr : instr_q;

  lc3x_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .raddr_a_i (rd_instr[8:6]),
    .raddr_b_i (rd_instr[2:0]),
    .we_i      (ex_fire && ex_res.wr),
    .waddr_i   (ex_res.wreg),
    .wdata_i   (ex_res.wval),
    .rdata_a_o (src_a),
    .rdata_b_o (src_b)
  );

  lc3x_exec u_exec (
    .instr_i (instr_q),
    .src_a_i (src_a),
    .src_b_i (src_b),
    .pc_i    (pc_q),
    .flags_i (flags_q),
    .halt_i  (halt_q),
    .res_o   (ex_res)
  );

  always_comb begin
    in_vld_d  = in_vld_q;
    pc_d      = pc_q;
    flags_d   = flags_q;
    halt_d    = halt_q;
    out_vld_d = out_vld_q;
    if (in_acc) begin
      in_vld_d = 1'b1;
    end else if (ex_fire) begin
      in_vld_d = 1'b0;
    end
    if (ex_fire) begin
      pc_d      = ex_res.pc;
      flags_d   = ex_res.flags;
      halt_d    = ex_res.halt;
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
    if (cfg_i.valid) begin
      pc_d = cfg_i.start_address;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      pc_q      <= '0;
      flags_q   <= '0;
      halt_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      pc_q      <= pc_d;
      flags_q   <= flags_d;
      halt_q    <= halt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      instr_q <= in_i.instr;
    end
    if (ex_fire) begin
      res_q <= ex_res;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.fetch_address = res_q.pc;
  assign out_o.wrote         = res_q.wr;
  assign out_o.written_reg   = res_q.wreg;
  assign out_o.written_value = res_q.wval;
  assign out_o.cond_flags    = res_q.flags;
  assign out_o.halted        = res_q.halt;
  assign out_o.unimplemented = res_q.unimp;

endmodule

`default_nettype wire
